### rtl/core/sgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgb_pkg: shared types and helpers for the separable Gaussian blur
// Queue item layout, configuration bundle, coefficient and edge helpers.
// ----------------------------------------------------------------------------
package sgb_pkg;

	localparam int DEF_MAX_WIDTH      = 512;
	localparam int DEF_MAX_HEIGHT     = 512;
	localparam int DEF_MAX_HALF_WIDTH = 6;
	localparam int DEF_FRAC_BITS      = 10;

	localparam int TAP_W   = 11;
	localparam int PIX_W   = 8;
	localparam int POS_W   = 9;
	localparam int SUM_W   = 23;  // 13 taps * 2047 * 255 fits
	localparam int COORD_W = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] REG_HALF_WIDTH   = 3'd0;
	localparam logic [2:0] REG_TAPS_NEAR    = 3'd1;
	localparam logic [2:0] REG_TAPS_FAR     = 3'd2;
	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd3;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;
	localparam logic [2:0] REG_COLOR_MODE   = 3'd5;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef struct packed {
		logic [2:0]  half_width;
		logic [43:0] taps_near;
		logic [32:0] taps_far;
		logic [9:0]  frame_width;
		logic [9:0]  frame_height;
		logic        color_mode;
	} sgb_cfg_t;

	typedef struct packed {
		logic             is_read;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [23:0]      pix;
	} sgb_item_t;

	function automatic int unsigned clamp_size(logic [9:0] v, int unsigned mx);
		int unsigned r;
		r = int'(v);
		if (r == 0) r = 1;
		if (r > mx) r = mx;
		return r;
	endfunction

	function automatic logic [TAP_W-1:0] coef(logic [43:0] near, logic [32:0] far,
	                                          logic [2:0] off);
		logic [TAP_W-1:0] c;
		case (off)
			3'd0: c = near[10:0];
			3'd1: c = near[21:11];
			3'd2: c = near[32:22];
			3'd3: c = near[43:33];
			3'd4: c = far[10:0];
			3'd5: c = far[21:11];
			3'd6: c = far[32:22];
			default: c = '0;
		endcase
		return c;
	endfunction

	// mirror at both ends, then clamp for frames smaller than the kernel
	function automatic logic [COORD_W-1:0] mirror(logic signed [COORD_W-1:0] s,
	                                              logic signed [COORD_W-1:0] last);
		logic signed [COORD_W-1:0] t;
		t = s;
		if (t < 0) t = -t;
		if (t > last) t = (last <<< 1) - t;
		if (t < 0) t = '0;
		if (t > last) t = last;
		return t;
	endfunction

	function automatic logic [PIX_W-1:0] sat_shift(logic [SUM_W-1:0] sum, int frac);
		logic [SUM_W-1:0] v;
		v = sum >> frac;
		return (v > SUM_W'(255)) ? 8'hFF : v[PIX_W-1:0];
	endfunction

endpackage

### rtl/core/sgb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgb_queue: short item queue
// Decouples the accepting front end from the filter engine.
// ----------------------------------------------------------------------------
module sgb_queue
	import sgb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sgb_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output sgb_item_t head
);
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	sgb_item_t       slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wptr_q, rptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)  rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end
endmodule

### rtl/core/sgb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgb_front: configuration registers and input classification
// Holds the registers, drops writes outside the store, clamps read positions.
// ----------------------------------------------------------------------------
module sgb_front
	import sgb_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [43:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        s_tuser,
	output sgb_cfg_t    cfg,
	output logic        push,
	output sgb_item_t   push_item,
	input  logic        full
);
	sgb_cfg_t    cfg_q;
	logic [8:0]  px, py;
	int unsigned w, hgt;

	assign cfg       = cfg_q;
	assign cfg_ready = 1'b1;
	assign s_tready  = !full;

	assign px  = s_tdata[8:0];
	assign py  = s_tdata[17:9];
	assign w   = clamp_size(cfg_q.frame_width, MAX_WIDTH);
	assign hgt = clamp_size(cfg_q.frame_height, MAX_HEIGHT);

	always_comb begin
		push_item.is_read = (s_tuser == CMD_READ);
		push_item.pos_x   = px;
		push_item.pos_y   = py;
		push_item.pix     = {16'h0, s_tdata[25:18]};
		if (cfg_q.color_mode) push_item.pix[23:8] = {s_tdata[41:34], s_tdata[33:26]};
		push = s_tvalid && !full;
		if (s_tuser == CMD_READ) begin
			if (int'(px) >= w)   push_item.pos_x = POS_W'(w - 1);
			if (int'(py) >= hgt) push_item.pos_y = POS_W'(hgt - 1);
		end else if (int'(px) >= MAX_WIDTH || int'(py) >= MAX_HEIGHT) begin
			push = 1'b0;  // write outside the store is dropped
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_width   <= 3'd1;
			cfg_q.taps_near    <= 44'd1024;
			cfg_q.taps_far     <= '0;
			cfg_q.frame_width  <= 10'd512;
			cfg_q.frame_height <= 10'd512;
			cfg_q.color_mode   <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HALF_WIDTH:   cfg_q.half_width   <= cfg_data[2:0];
				REG_TAPS_NEAR:    cfg_q.taps_near    <= cfg_data;
				REG_TAPS_FAR:     cfg_q.taps_far     <= cfg_data[32:0];
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[9:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[9:0];
				REG_COLOR_MODE:   cfg_q.color_mode   <= cfg_data[0];
				default: ;
			endcase
		end
	end
endmodule

### rtl/core/sgb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgb_back: frame store and filter engine
// Walks the (2h+1)x(2h+1) window one store read a cycle, three channels wide.
// ----------------------------------------------------------------------------
module sgb_back
	import sgb_pkg::*;
#(
	parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
	parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH,
	parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  sgb_cfg_t    cfg,
	input  logic        empty,
	input  sgb_item_t   head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata
);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [23:0] mem [DEPTH];
	logic [23:0] rdata_s1;

	logic [1:0]     state_q;
	logic [XW-1:0]  cx_q;
	logic [YW-1:0]  cy_q;
	logic [3:0]     dx_q, dy_q;
	logic [3:0]     span;
	logic [2:0]     h;
	int unsigned    w, hgt;
	logic [2:0]     offx, offy;
	logic signed [COORD_W-1:0] sx, sy;
	logic [COORD_W-1:0] col, row;
	logic [AW-1:0]  addr;
	logic           wr_en, issue, last_col, last_row;

	logic           v_s1, first_col_s1, last_col_s1, first_row_s1, fin_s1;
	logic [TAP_W-1:0] hc_s1, vc_s1, vc_s2;
	logic           rowend_s2, first_row_s2, fin_s2, fin_s3;
	logic [SUM_W-1:0] hsum_q [3];
	logic [SUM_W-1:0] vsum_q [3];
	logic           out_free;

	assign h    = (cfg.half_width == 3'd0) ? 3'd1 :
	              (int'(cfg.half_width) > MAX_HALF_WIDTH) ? 3'(MAX_HALF_WIDTH) :
	              cfg.half_width;
	assign span = {h, 1'b0};
	assign w    = clamp_size(cfg.frame_width, MAX_WIDTH);
	assign hgt  = clamp_size(cfg.frame_height, MAX_HEIGHT);

	assign offx = (dx_q >= 4'(h)) ? 3'(dx_q - 4'(h)) : 3'(4'(h) - dx_q);
	assign offy = (dy_q >= 4'(h)) ? 3'(dy_q - 4'(h)) : 3'(4'(h) - dy_q);
	assign sx   = signed'(COORD_W'(cx_q)) + signed'(COORD_W'(dx_q)) - signed'(COORD_W'(h));
	assign sy   = signed'(COORD_W'(cy_q)) + signed'(COORD_W'(dy_q)) - signed'(COORD_W'(h));
	assign col  = mirror(sx, signed'(COORD_W'(w - 1)));
	assign row  = mirror(sy, signed'(COORD_W'(hgt - 1)));

	assign last_col = (dx_q == span);
	assign last_row = (dy_q == span);
	assign issue    = (state_q == ST_RUN);
	assign wr_en    = (state_q == ST_IDLE) && !empty && !head.is_read;
	assign pop      = (state_q == ST_IDLE) && !empty;
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		if (state_q == ST_IDLE)
			addr = AW'(head.pos_y) * AW'(MAX_WIDTH) + AW'(head.pos_x);
		else
			addr = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[addr] <= head.pix;
		rdata_s1 <= mem[addr];
	end

	// horizontal then vertical accumulate, one multiply per channel per stage
	always_ff @(posedge clk) begin
		hc_s1        <= coef(cfg.taps_near, cfg.taps_far, offx);
		vc_s1        <= coef(cfg.taps_near, cfg.taps_far, offy);
		first_col_s1 <= (dx_q == '0);
		last_col_s1  <= last_col;
		first_row_s1 <= (dy_q == '0);
		fin_s1       <= last_col && last_row;
		vc_s2        <= vc_s1;
		first_row_s2 <= first_row_s1;
		fin_s2       <= fin_s1;
		for (int c = 0; c < 3; c++) begin
			if (v_s1)
				hsum_q[c] <= (first_col_s1 ? '0 : hsum_q[c])
				           + SUM_W'(hc_s1) * SUM_W'(rdata_s1[8*c +: 8]);
			if (rowend_s2)
				vsum_q[c] <= (first_row_s2 ? '0 : vsum_q[c])
				           + SUM_W'(vc_s2) * SUM_W'(sat_shift(hsum_q[c], FRAC_BITS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			v_s1      <= 1'b0;
			rowend_s2 <= 1'b0;
			fin_s3    <= 1'b0;
			dx_q      <= '0;
			dy_q      <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
			m_tvalid  <= 1'b0;
			m_tdata   <= '0;
		end else begin
			v_s1      <= issue;
			rowend_s2 <= v_s1 && last_col_s1;
			fin_s3    <= v_s1 && last_col_s1 && fin_s2 == 1'b0 && fin_s1;
			// DONE reloads the output register itself
			if (m_tvalid && m_tready && state_q != ST_DONE) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty && head.is_read) begin
						cx_q    <= XW'(head.pos_x);
						cy_q    <= YW'(head.pos_y);
						dx_q    <= '0;
						dy_q    <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_col) begin
						dx_q <= '0;
						dy_q <= dy_q + 1'b1;
						if (last_row) state_q <= ST_DRAIN;
					end else begin
						dx_q <= dx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (fin_s3) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata[7:0] <= sat_shift(vsum_q[0], FRAC_BITS);
						m_tdata[15:8] <= cfg.color_mode ? sat_shift(vsum_q[1], FRAC_BITS) : 8'h0;
						m_tdata[23:16] <= cfg.color_mode ? sat_shift(vsum_q[2], FRAC_BITS) : 8'h0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/core/separable_gaussian_blur.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_gaussian_blur: stored-frame separable Gaussian filter
// Write items store pixels, read items return blurred pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tuser = cmd (0 write, 1 read); tdata carries pos_x,
//   pos_y and three 8-bit channel values. A write produces no output item; a
//   read produces one item on m_* carrying blur_a, blur_b, blur_c.
//   Configuration port cfg_*: register index and data, always ready; write
//   only while no item is in flight.
//   A write is stored straight from the engine's idle state. A read walks the
//   (2h+1)^2 window, paced by the single read port of the frame store: one
//   window pixel is fetched per cycle, all channels in parallel.
//   A two-item queue sits in front of the engine, so input is taken while
//   the engine works or a result waits on the output register.
//   Reset restores the register defaults and empties the queue and output;
//   the frame store holds no reset value and must be written before reads.
//   When the receiver stalls, the engine holds a finished result until the
//   output register drains, and the input side stalls once the queue fills.
// ----------------------------------------------------------------------------
module separable_gaussian_blur
	import sgb_pkg::*;
#(
	parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
	parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH,
	parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [43:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // pos_x, pos_y, chan_a, chan_b, chan_c, zero pad
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // blur_a, blur_b, blur_c
);
	sgb_cfg_t  cfg;
	sgb_item_t push_item, head;
	logic      push, full, pop, empty;

	sgb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.cfg, .push, .push_item, .full
	);

	sgb_queue u_queue (
		.clk, .arst_n, .push, .push_item, .full, .pop, .empty, .head
	);

	sgb_back #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH), .FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk, .arst_n, .cfg, .empty, .head, .pop, .m_tvalid, .m_tready, .m_tdata
	);
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for separable_gaussian_blur
// Writes pixels, reads blurred pixels and checks every result against a
// behavioral blur kept in the bench, over many kernel and frame settings
// with random gaps on the input stream and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_top;
	import sgb_pkg::*;

	localparam int MAXW        = 512;
	localparam int MAXH        = 512;
	localparam int MAXHW       = 6;
	localparam int FRAC        = 10;
	localparam int SETTLE_CYC  = 200;
	localparam int HOLD_CYC    = 600;
	localparam int STALL_LIMIT = 5000;
	localparam int ITEM_GOAL   = 1500;
	localparam int ROUND_ITEMS = 60;

	typedef struct {
		logic       cmd;
		bit [8:0]   x;
		bit [8:0]   y;
		bit [7:0]   a;
		bit [7:0]   b;
		bit [7:0]   c;
	} pix_op_t;

	typedef struct {
		bit [7:0] a;
		bit [7:0] b;
		bit [7:0] c;
	} blur_px_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [43:0] cfg_data;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tuser = CMD_WRITE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	separable_gaussian_blur u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// bench copy of the registers
	bit [2:0]  sh_hw    = 3'd1;
	bit [43:0] sh_near  = 44'd1024;
	bit [32:0] sh_far   = 33'd0;
	bit [9:0]  sh_w     = 10'd512;
	bit [9:0]  sh_h     = 10'd512;
	bit        sh_color = 1'b1;

	bit [23:0] pix_mem [0:MAXW*MAXH-1];      // filled at acceptance
	bit        pix_planned [0:MAXW*MAXH-1];  // filled at generation

	pix_op_t  pending_ops[$];
	blur_px_t blur_expected[$];

	int tx_idle = 0;
	int rx_idle = 0;
	int hold_cnt = 0;
	bit hold_go = 0;
	int errors = 0;
	int reads_checked = 0;
	int writes_done = 0;
	int items_made = 0;
	int setups = 0;
	int quiet_cycles = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int eff_size(bit [9:0] v, int mx);
		if (v == 0) return 1;
		if (v > mx) return mx;
		return int'(v);
	endfunction

	function automatic int eff_hw();
		if (sh_hw == 0) return 1;
		if (sh_hw > MAXHW) return MAXHW;
		return int'(sh_hw);
	endfunction

	function automatic int fold_edge(int s, int n);
		int last;
		last = n - 1;
		if (s < 0) s = -s;
		if (s > last) s = 2 * last - s;
		if (s < 0) s = 0;
		if (s > last) s = last;
		return s;
	endfunction

	function automatic longint tap_at(int off);
		if (off < 4) return longint'((sh_near >> (11 * off)) & 44'h7FF);
		return longint'((sh_far >> (11 * (off - 4))) & 33'h7FF);
	endfunction

	function automatic int clip_q(longint sum);
		longint v;
		v = sum >>> FRAC;
		return (v > 255) ? 255 : int'(v);
	endfunction

	function automatic int row_blur(int x, int row, int ch, int h, int w);
		longint sum;
		int col;
		sum = 0;
		for (int d = -h; d <= h; d++) begin
			col = fold_edge(x + d, w);
			sum += tap_at(d < 0 ? -d : d) * longint'((pix_mem[row * MAXW + col] >> (8 * ch)) & 8'hFF);
		end
		return clip_q(sum);
	endfunction

	function automatic blur_px_t blur_at(int px, int py);
		blur_px_t r;
		int w, hh, h, x, y, row;
		longint sum;
		bit [7:0] v [3];
		w  = eff_size(sh_w, MAXW);
		hh = eff_size(sh_h, MAXH);
		h  = eff_hw();
		x  = px >= w ? w - 1 : px;
		y  = py >= hh ? hh - 1 : py;
		v[0] = 0;
		v[1] = 0;
		v[2] = 0;
		for (int ch = 0; ch < (sh_color ? 3 : 1); ch++) begin
			sum = 0;
			for (int d = -h; d <= h; d++) begin
				row = fold_edge(y + d, hh);
				sum += tap_at(d < 0 ? -d : d) * longint'(row_blur(x, row, ch, h, w));
			end
			v[ch] = 8'(clip_q(sum));
		end
		r.a = v[0];
		r.b = v[1];
		r.c = v[2];
		return r;
	endfunction

	task automatic report_mismatch(string field, int want, int got);
		$display("[%0t] %s mismatch: expected %0d, got %0d", $time, field, want, got);
		errors++;
	endtask

	// ---------------- input driver ----------------
	bit s_took;
	always @(negedge clk) begin
		pix_op_t op;
		if (arst_n && (!s_tvalid || s_took)) begin
			if (pending_ops.size() > 0 && $urandom_range(99) >= tx_idle) begin
				op = pending_ops.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= op.cmd;
				s_tdata  <= {6'd0, op.c, op.b, op.a, op.y, op.x};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------- output side ready ----------------
	always @(negedge clk) begin
		if (hold_go && hold_cnt == 0) hold_cnt = HOLD_CYC;
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// ---------------- prediction and check ----------------
	always @(posedge clk) begin
		blur_px_t want;
		int x, y;
		s_took = s_tvalid && s_tready;
		if (s_took) begin
			x = int'(s_tdata[8:0]);
			y = int'(s_tdata[17:9]);
			if (s_tuser == CMD_WRITE) begin
				pix_mem[y * MAXW + x] = sh_color ? s_tdata[41:18] : {16'd0, s_tdata[25:18]};
				writes_done++;
			end else begin
				blur_expected.push_back(blur_at(x, y));
			end
		end
		if (m_tvalid && m_tready) begin
			if (blur_expected.size() == 0) begin
				report_mismatch("unexpected result", 0, int'(m_tdata));
			end else begin
				want = blur_expected.pop_front();
				if (m_tdata[7:0] != want.a) report_mismatch("blur_a", want.a, m_tdata[7:0]);
				if (m_tdata[15:8] != want.b) report_mismatch("blur_b", want.b, m_tdata[15:8]);
				if (m_tdata[23:16] != want.c) report_mismatch("blur_c", want.c, m_tdata[23:16]);
				reads_checked++;
			end
		end
		if (s_took || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	task automatic write_reg(logic [2:0] idx, logic [43:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HALF_WIDTH:   sh_hw    = val[2:0];
			REG_TAPS_NEAR:    sh_near  = val[43:0];
			REG_TAPS_FAR:     sh_far   = val[32:0];
			REG_FRAME_WIDTH:  sh_w     = val[9:0];
			REG_FRAME_HEIGHT: sh_h     = val[9:0];
			REG_COLOR_MODE:   sh_color = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup(bit [2:0] hw, bit [43:0] nr, bit [32:0] fr, bit [9:0] w,
	                     bit [9:0] h, bit color);
		write_reg(REG_HALF_WIDTH, 44'(hw));
		write_reg(REG_TAPS_NEAR, nr);
		write_reg(REG_TAPS_FAR, 44'(fr));
		write_reg(REG_FRAME_WIDTH, 44'(w));
		write_reg(REG_FRAME_HEIGHT, 44'(h));
		write_reg(REG_COLOR_MODE, 44'(color));
		setups++;
	endtask

	// wait until all work drained; writes leave no result so pad by engine latency
	task automatic drain();
		do @(posedge clk);
		while (pending_ops.size() > 0 || s_tvalid || blur_expected.size() > 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic put_write(int x, int y, bit [7:0] a, bit [7:0] b, bit [7:0] c);
		pix_op_t op;
		op.cmd = CMD_WRITE;
		op.x = 9'(x);
		op.y = 9'(y);
		op.a = a;
		op.b = b;
		op.c = c;
		pending_ops.push_back(op);
		pix_planned[y * MAXW + x] = 1'b1;
		items_made++;
	endtask

	// any window pixel with no write planned yet gets a random write first
	task automatic put_read(int x, int y);
		pix_op_t op;
		int w, hh, h, cx, cy, col, row;
		w  = eff_size(sh_w, MAXW);
		hh = eff_size(sh_h, MAXH);
		h  = eff_hw();
		cx = x >= w ? w - 1 : x;
		cy = y >= hh ? hh - 1 : y;
		for (int dy = -h; dy <= h; dy++)
			for (int dx = -h; dx <= h; dx++) begin
				row = fold_edge(cy + dy, hh);
				col = fold_edge(cx + dx, w);
				if (!pix_planned[row * MAXW + col])
					put_write(col, row, 8'($urandom), 8'($urandom), 8'($urandom));
			end
		op.cmd = CMD_READ;
		op.x = 9'(x);
		op.y = 9'(y);
		op.a = 8'($urandom);
		op.b = 8'($urandom);
		op.c = 8'($urandom);
		pending_ops.push_back(op);
		items_made++;
	endtask

	function automatic bit [43:0] rand_taps(int n);
		bit [43:0] t;
		t = 0;
		for (int i = 0; i < n; i++)
			t |= 44'($urandom_range(99) < 70 ? $urandom_range(0, 300) : $urandom_range(0, 2047))
			     << (11 * i);
		return t;
	endfunction

	function automatic bit [9:0] rand_size();
		int r;
		r = $urandom_range(99);
		if (r < 80) return 10'($urandom_range(1, 20));
		if (r < 88) return 10'($urandom_range(0, 2));
		return 10'($urandom_range(500, 1023));
	endfunction

	initial begin
		int w, hh, start_items;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		tx_idle = 28;
		rx_idle = 57;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register defaults: corners with extreme pixels
		put_write(0, 0, 8'hFF, 8'h00, 8'hFF);
		put_write(511, 511, 8'h00, 8'hFF, 8'h00);
		put_read(0, 0);
		put_read(511, 511);
		put_read(255, 256);
		drain();

		// out-of-range half width and frame size, saturating taps, one channel
		setup(3'd7, '1, '1, 10'd1023, 10'd0, 1'b0);
		put_write(511, 0, 8'hFF, 8'hAA, 8'h55);
		put_read(511, 0);
		put_read(300, 5);
		put_read(0, 511);
		drain();

		// tiny frame with a kernel wider than it, read outside the frame
		setup(3'd6, rand_taps(4), 33'(rand_taps(3)), 10'd2, 10'd3, 1'b1);
		put_read(1, 2);
		put_read(511, 511);
		put_read(0, 0);
		drain();

		setup(3'd0, 44'd1024 << 11, 33'd0, 10'd1, 10'd1, 1'b1);
		put_read(0, 0);
		put_read(7, 9);
		drain();

		// random phases; the second one holds the receiver off while reads pile up
		while (items_made < ITEM_GOAL) begin
			if (items_made >= 1000) begin
				tx_idle = 0;
				rx_idle = 0;
			end else if (items_made >= 500) begin
				tx_idle = 57;
				rx_idle = 28;
			end
			setup(3'($urandom_range(0, 7)), rand_taps(4), 33'(rand_taps(3)), rand_size(),
			      rand_size(), 1'($urandom_range(1)));
			w  = eff_size(sh_w, MAXW);
			hh = eff_size(sh_h, MAXH);
			start_items = items_made;
			if (setups == 5) begin
				for (int i = 0; i < 8; i++)
					put_read($urandom_range(0, w - 1), $urandom_range(0, hh - 1));
				@(posedge clk);
				hold_go = 1'b1;
				@(posedge clk);
				hold_go = 1'b0;
			end
			// large frames add many window writes per read, so cap each round
			for (int i = 0; i < 40 && items_made - start_items < ROUND_ITEMS; i++) begin
				case ($urandom_range(9))
					0: put_write($urandom_range(0, 511), $urandom_range(0, 511),
					             8'($urandom), 8'($urandom), 8'($urandom));
					1: put_read($urandom_range(0, 511), $urandom_range(0, 511));
					2, 3, 4: put_write($urandom_range(0, w - 1), $urandom_range(0, hh - 1),
					                   8'($urandom), 8'($urandom), 8'($urandom));
					default: put_read($urandom_range(0, w - 1), $urandom_range(0, hh - 1));
				endcase
			end
			drain();
		end

		$display("covered %0d register setups, %0d pixel writes, %0d blurred reads checked",
		         setups, writes_done, reads_checked);
		$display("kernels from 3 to 13 taps, tiny to full frames, one and three channels");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d errors", errors);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### separable_gaussian_blur.f
rtl/core/sgb_pkg.sv
rtl/core/sgb_queue.sv
rtl/core/sgb_front.sv
rtl/core/sgb_back.sv
rtl/core/separable_gaussian_blur.sv
tb/sv/tb_top.sv
